// ===== rtl/bvhacb_pkg.sv =====
// Shared types, constants and box arithmetic for the cluster tree builder.
// Depends on nothing; the interfaces, datapath, controller and top unit use it.
`default_nettype none

package bvhacb_pkg;

    localparam int MAX_INSTANCES = 32;
    localparam int COORD_BITS    = 16;
    localparam int NODE_SLOTS    = 64;
    localparam int POS_W         = $clog2(MAX_INSTANCES);
    localparam int CNT_W         = POS_W + 1;
    localparam int NODE_W        = $clog2(NODE_SLOTS);
    localparam int FREE_W        = NODE_W + 1;
    localparam int INST_W        = 5;
    localparam int EXT_W         = COORD_BITS;
    localparam int PXY_W         = 2 * EXT_W;
    localparam int VOL_W         = 3 * EXT_W;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
    } box_t;

    typedef struct packed {
        box_t              box;
        logic [NODE_W-1:0] left;
        logic [NODE_W-1:0] right;
        logic [INST_W-1:0] inst;
    } node_t;

    typedef enum logic [1:0] {
        NW_LOAD  = 2'd0,
        NW_MERGE = 2'd1,
        NW_COPY  = 2'd2
    } nwsel_t;

    typedef struct packed {
        logic              act_we;
        logic [POS_W-1:0]  act_waddr;
        logic [NODE_W-1:0] act_wdata;
        logic [POS_W-1:0]  act_raddr;
        logic              node_we;
        logic [NODE_W-1:0] node_waddr;
        logic [NODE_W-1:0] node_raddr;
        nwsel_t            nwsel;
        logic [NODE_W-1:0] wr_left;
        logic [NODE_W-1:0] wr_right;
        logic [INST_W-1:0] wr_inst;
        logic              me_load;
        logic              best_load;
        logic              out_load;
        logic [NODE_W-1:0] out_num;
        logic              out_final;
    } cmd_t;

    typedef struct packed {
        logic [NODE_W-1:0] act_rdata;
        logic              vol_less;
        logic              out_done;
    } sts_t;

    function automatic coord_t cmin(coord_t p, coord_t q);
        return ($signed(p) < $signed(q)) ? p : q;
    endfunction

    function automatic coord_t cmax(coord_t p, coord_t q);
        return ($signed(p) > $signed(q)) ? p : q;
    endfunction

    function automatic box_t union_box(box_t p, box_t q);
        box_t r;
        r.min_x = cmin(p.min_x, q.min_x);
        r.min_y = cmin(p.min_y, q.min_y);
        r.min_z = cmin(p.min_z, q.min_z);
        r.max_x = cmax(p.max_x, q.max_x);
        r.max_y = cmax(p.max_y, q.max_y);
        r.max_z = cmax(p.max_z, q.max_z);
        return r;
    endfunction

    // An inverted axis counts as zero extent.
    function automatic logic [EXT_W-1:0] extent(coord_t lo, coord_t hi);
        logic signed [COORD_BITS:0] diff;
        diff = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
        return (diff > 0) ? diff[EXT_W-1:0] : '0;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bvhacb_if.sv =====
// Channel interfaces for instance boxes in and tree nodes out.
// Depends on bvhacb_pkg for field widths.
`default_nettype none

interface bvhacb_in_if;
    logic valid;
    logic ready;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] min_x;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] min_y;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] min_z;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] max_x;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] max_y;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] max_z;
    logic final_instance;

    modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                    final_instance, input ready);
    modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  final_instance, output ready);
endinterface

interface bvhacb_out_if;
    logic valid;
    logic ready;
    logic [bvhacb_pkg::NODE_W-1:0] node_number;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] box_min_x;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] box_min_y;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] box_min_z;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] box_max_x;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] box_max_y;
    logic signed [bvhacb_pkg::COORD_BITS-1:0] box_max_z;
    logic [bvhacb_pkg::NODE_W-1:0] left_child;
    logic [bvhacb_pkg::NODE_W-1:0] right_child;
    logic [bvhacb_pkg::INST_W-1:0] instance_number;
    logic final_node;

    modport source (output valid, node_number, box_min_x, box_min_y, box_min_z,
                    box_max_x, box_max_y, box_max_z, left_child, right_child,
                    instance_number, final_node, input ready);
    modport sink (input valid, node_number, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, left_child, right_child,
                  instance_number, final_node, output ready);
endinterface

`default_nettype wire

// ===== rtl/bvh_agglomerative_cluster_build_unit.sv =====
// Instance boxes load at one transfer per cycle while the unit is idle. The transfer
// that carries final_instance starts the build: for N boxes, each best-match search
// scans the active list one candidate at a time through the single node memory read
// port, and the list size is tested before the next search of the chain. The 2N
// nodes then leave one at a time, each held until it is taken before the next is
// read; no input is taken from the final transfer until the last node has been
// delivered.
// Depends on bvhacb_pkg, bvhacb_if, bvhacb_ram, bvhacb_datapath and bvhacb_ctrl.
`default_nettype none

module bvh_agglomerative_cluster_build_unit (
    input  logic         clk,
    input  logic         rst_n,
    bvhacb_in_if.sink    inst_in,
    bvhacb_out_if.source node_out
);
    import bvhacb_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    box_t              in_box;
    node_t             out_node;
    logic [NODE_W-1:0] out_num;
    logic              out_final;
    logic              out_valid;
    logic              in_ready;

    assign in_box.min_x = inst_in.min_x;
    assign in_box.min_y = inst_in.min_y;
    assign in_box.min_z = inst_in.min_z;
    assign in_box.max_x = inst_in.max_x;
    assign in_box.max_y = inst_in.max_y;
    assign in_box.max_z = inst_in.max_z;
    assign inst_in.ready = in_ready;

    bvhacb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (inst_in.valid),
        .in_final (inst_in.final_instance),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    bvhacb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_box    (in_box),
        .out_ready (node_out.ready),
        .cmd       (cmd),
        .sts       (sts),
        .out_node  (out_node),
        .out_num   (out_num),
        .out_final (out_final),
        .out_valid (out_valid)
    );

    assign node_out.valid           = out_valid;
    assign node_out.node_number     = out_num;
    assign node_out.box_min_x       = out_node.box.min_x;
    assign node_out.box_min_y       = out_node.box.min_y;
    assign node_out.box_min_z       = out_node.box.min_z;
    assign node_out.box_max_x       = out_node.box.max_x;
    assign node_out.box_max_y       = out_node.box.max_y;
    assign node_out.box_max_z       = out_node.box.max_z;
    assign node_out.left_child      = out_node.left;
    assign node_out.right_child     = out_node.right;
    assign node_out.instance_number = out_node.inst;
    assign node_out.final_node      = out_final;
endmodule

`default_nettype wire

// ===== rtl/bvhacb_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module bvhacb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;
endmodule

`default_nettype wire

// ===== rtl/bvhacb_datapath.sv =====
// Datapath: node and active-list memories, union volume pipeline, output register.
// Depends on bvhacb_pkg and bvhacb_ram.
`default_nettype none

module bvhacb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  bvhacb_pkg::box_t    in_box,
    input  logic                out_ready,
    input  bvhacb_pkg::cmd_t    cmd,
    output bvhacb_pkg::sts_t    sts,
    output bvhacb_pkg::node_t   out_node,
    output logic [bvhacb_pkg::NODE_W-1:0] out_num,
    output logic                out_final,
    output logic                out_valid
);
    import bvhacb_pkg::*;

    node_t             node_rd;
    node_t             node_wr;
    logic [NODE_W-1:0] act_rd;
    box_t              me_reg;
    box_t              ub;
    logic [PXY_W-1:0]  pxy_reg;
    logic [EXT_W-1:0]  ez_reg;
    logic [VOL_W-1:0]  vol_reg;
    logic [VOL_W-1:0]  best_vol_reg;
    node_t             out_reg;
    logic [NODE_W-1:0] out_num_reg;
    logic              out_final_reg;
    logic              out_valid_reg;
    logic              out_valid_next;

    bvhacb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_INSTANCES)) u_act_ram (
        .clk   (clk),
        .we    (cmd.act_we),
        .waddr (cmd.act_waddr),
        .wdata (cmd.act_wdata),
        .raddr (cmd.act_raddr),
        .rdata (act_rd)
    );

    bvhacb_ram #(.WIDTH($bits(node_t)), .DEPTH(NODE_SLOTS)) u_node_ram (
        .clk   (clk),
        .we    (cmd.node_we),
        .waddr (cmd.node_waddr),
        .wdata (node_wr),
        .raddr (cmd.node_raddr),
        .rdata (node_rd)
    );

    assign ub = union_box(me_reg, node_rd.box);

    always_comb
    begin
        node_wr = node_rd;
        case (cmd.nwsel)
            NW_LOAD:
            begin
                node_wr.box   = in_box;
                node_wr.left  = '0;
                node_wr.right = '0;
                node_wr.inst  = cmd.wr_inst;
            end
            NW_MERGE:
            begin
                node_wr.box   = ub;
                node_wr.left  = cmd.wr_left;
                node_wr.right = cmd.wr_right;
                node_wr.inst  = '0;
            end
            default:
            begin
                node_wr = node_rd;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pxy_reg <= PXY_W'(extent(ub.min_x, ub.max_x)) * PXY_W'(extent(ub.min_y, ub.max_y));
        ez_reg  <= extent(ub.min_z, ub.max_z);
        vol_reg <= VOL_W'(pxy_reg) * VOL_W'(ez_reg);
        if (cmd.me_load)
        begin
            me_reg <= node_rd.box;
        end
        if (cmd.best_load)
        begin
            best_vol_reg <= vol_reg;
        end
        if (cmd.out_load)
        begin
            out_reg       <= node_rd;
            out_num_reg   <= cmd.out_num;
            out_final_reg <= cmd.out_final;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.act_rdata = act_rd;
    assign sts.vol_less  = vol_reg < best_vol_reg;
    assign sts.out_done  = out_valid_reg && out_ready;
    assign out_node      = out_reg;
    assign out_num       = out_num_reg;
    assign out_final     = out_final_reg;
    assign out_valid     = out_valid_reg;
endmodule

`default_nettype wire

// ===== rtl/bvhacb_ctrl.sv =====
// Controller: loads instances, walks best-match chains, merges, and sequences output.
// Depends on bvhacb_pkg; drives bvhacb_datapath through the command struct.
`default_nettype none

module bvhacb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_final,
    output logic             in_ready,
    input  bvhacb_pkg::sts_t sts,
    output bvhacb_pkg::cmd_t cmd
);
    import bvhacb_pkg::*;

    typedef enum logic [23:0] {
        S_IDLE    = 24'h000001,
        S_ME0     = 24'h000002,
        S_ME1     = 24'h000004,
        S_ME2     = 24'h000008,
        S_CA      = 24'h000010,
        S_CN      = 24'h000020,
        S_CV1     = 24'h000040,
        S_CV2     = 24'h000080,
        S_CV3     = 24'h000100,
        S_BPDONE  = 24'h000200,
        S_LOOP    = 24'h000400,
        S_M1      = 24'h000800,
        S_M2      = 24'h001000,
        S_M3      = 24'h002000,
        S_M4      = 24'h004000,
        S_M5      = 24'h008000,
        S_M6      = 24'h010000,
        S_R1      = 24'h020000,
        S_R2      = 24'h040000,
        S_R3      = 24'h080000,
        S_ORD     = 24'h100000,
        S_OLD     = 24'h200000,
        S_OWAIT   = 24'h400000,
        S_START   = 24'h800000
    } state_t;

    typedef enum logic {
        TGT_B = 1'b0,
        TGT_C = 1'b1
    } tgt_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [FREE_W-1:0] nfree_reg, nfree_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [POS_W-1:0]  a_reg, a_next;
    logic [POS_W-1:0]  b_reg, b_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [POS_W-1:0]  best_reg, best_next;
    logic              found_reg, found_next;
    tgt_t              tgt_reg, tgt_next;
    logic [NODE_W-1:0] na_reg, na_next;
    logic [NODE_W-1:0] nb_reg, nb_next;
    logic [NODE_W-1:0] oi_reg, oi_next;
    logic              room;
    logic [POS_W-1:0]  last_pos;

    assign room     = count_reg < CNT_W'(MAX_INSTANCES);
    assign last_pos = POS_W'(n_reg - CNT_W'(1));

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        nfree_next = nfree_reg;
        n_next     = n_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        pos_next   = pos_reg;
        idx_next   = idx_reg;
        best_next  = best_reg;
        found_next = found_reg;
        tgt_next   = tgt_reg;
        na_next    = na_reg;
        nb_next    = nb_reg;
        oi_next    = oi_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.nwsel  = NW_LOAD;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (room)
                    begin
                        cmd.node_we    = 1'b1;
                        cmd.node_waddr = NODE_W'(count_reg + CNT_W'(1));
                        cmd.nwsel      = NW_LOAD;
                        cmd.wr_inst    = INST_W'(count_reg);
                        cmd.act_we     = 1'b1;
                        cmd.act_waddr  = POS_W'(count_reg);
                        cmd.act_wdata  = NODE_W'(count_reg + CNT_W'(1));
                        count_next     = count_reg + CNT_W'(1);
                        nfree_next     = FREE_W'(count_reg) + FREE_W'(2);
                    end
                    if (in_final)
                    begin
                        n_next     = room ? count_reg + CNT_W'(1) : count_reg;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                a_next     = '0;
                pos_next   = '0;
                tgt_next   = TGT_B;
                state_next = S_ME0;
            end
            S_ME0:
            begin
                cmd.act_raddr = pos_reg;
                state_next    = S_ME1;
            end
            S_ME1:
            begin
                cmd.node_raddr = sts.act_rdata;
                state_next     = S_ME2;
            end
            S_ME2:
            begin
                cmd.me_load = 1'b1;
                idx_next    = '0;
                found_next  = 1'b0;
                best_next   = '0;
                state_next  = S_CA;
            end
            S_CA:
            begin
                if (idx_reg >= n_reg)
                begin
                    state_next = S_BPDONE;
                end
                else if (POS_W'(idx_reg) == pos_reg)
                begin
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    cmd.act_raddr = POS_W'(idx_reg);
                    state_next    = S_CN;
                end
            end
            S_CN:
            begin
                cmd.node_raddr = sts.act_rdata;
                state_next     = S_CV1;
            end
            S_CV1:
            begin
                state_next = S_CV2;
            end
            S_CV2:
            begin
                state_next = S_CV3;
            end
            S_CV3:
            begin
                if (!found_reg || sts.vol_less)
                begin
                    found_next    = 1'b1;
                    best_next     = POS_W'(idx_reg);
                    cmd.best_load = 1'b1;
                end
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_CA;
            end
            S_BPDONE:
            begin
                if (tgt_reg == TGT_B)
                begin
                    b_next     = best_reg;
                    state_next = S_LOOP;
                end
                else if (best_reg == a_reg)
                begin
                    state_next = S_M1;
                end
                else
                begin
                    a_next     = b_reg;
                    b_next     = best_reg;
                    state_next = S_LOOP;
                end
            end
            S_LOOP:
            begin
                if (n_reg <= CNT_W'(1))
                begin
                    state_next = S_R1;
                end
                else
                begin
                    pos_next   = b_reg;
                    tgt_next   = TGT_C;
                    state_next = S_ME0;
                end
            end
            S_M1:
            begin
                cmd.act_raddr = a_reg;
                state_next    = S_M2;
            end
            S_M2:
            begin
                na_next        = sts.act_rdata;
                cmd.act_raddr  = b_reg;
                cmd.node_raddr = sts.act_rdata;
                state_next     = S_M3;
            end
            S_M3:
            begin
                nb_next        = sts.act_rdata;
                cmd.me_load    = 1'b1;
                cmd.node_raddr = sts.act_rdata;
                state_next     = S_M4;
            end
            S_M4:
            begin
                cmd.node_we    = 1'b1;
                cmd.node_waddr = NODE_W'(nfree_reg);
                cmd.nwsel      = NW_MERGE;
                cmd.wr_left    = na_reg;
                cmd.wr_right   = nb_reg;
                cmd.act_we     = 1'b1;
                cmd.act_waddr  = a_reg;
                cmd.act_wdata  = NODE_W'(nfree_reg);
                state_next     = S_M5;
            end
            S_M5:
            begin
                cmd.act_raddr = last_pos;
                state_next    = S_M6;
            end
            S_M6:
            begin
                cmd.act_we    = 1'b1;
                cmd.act_waddr = b_reg;
                cmd.act_wdata = sts.act_rdata;
                if (a_reg == last_pos)
                begin
                    a_next   = b_reg;
                    pos_next = b_reg;
                end
                else
                begin
                    pos_next = a_reg;
                end
                n_next     = n_reg - CNT_W'(1);
                nfree_next = nfree_reg + FREE_W'(1);
                tgt_next   = TGT_B;
                state_next = S_ME0;
            end
            S_R1:
            begin
                cmd.act_raddr = a_reg;
                state_next    = S_R2;
            end
            S_R2:
            begin
                cmd.node_raddr = sts.act_rdata;
                state_next     = S_R3;
            end
            S_R3:
            begin
                cmd.node_we    = 1'b1;
                cmd.node_waddr = '0;
                cmd.nwsel      = NW_COPY;
                oi_next        = '0;
                state_next     = S_ORD;
            end
            S_ORD:
            begin
                cmd.node_raddr = oi_reg;
                state_next     = S_OLD;
            end
            S_OLD:
            begin
                cmd.out_load  = 1'b1;
                cmd.out_num   = oi_reg;
                cmd.out_final = (FREE_W'(oi_reg) + FREE_W'(1)) == nfree_reg;
                state_next    = S_OWAIT;
            end
            S_OWAIT:
            begin
                if (sts.out_done)
                begin
                    if ((FREE_W'(oi_reg) + FREE_W'(1)) == nfree_reg)
                    begin
                        count_next = '0;
                        nfree_next = FREE_W'(1);
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        oi_next    = oi_reg + NODE_W'(1);
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            nfree_reg <= FREE_W'(1);
            n_reg     <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            pos_reg   <= '0;
            idx_reg   <= '0;
            best_reg  <= '0;
            found_reg <= 1'b0;
            tgt_reg   <= TGT_B;
            na_reg    <= '0;
            nb_reg    <= '0;
            oi_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            nfree_reg <= nfree_next;
            n_reg     <= n_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
            best_reg  <= best_next;
            found_reg <= found_next;
            tgt_reg   <= tgt_next;
            na_reg    <= na_next;
            nb_reg    <= nb_next;
            oi_reg    <= oi_next;
        end
    end
endmodule

`default_nettype wire
